// ===== hdl/lws_pkg.sv =====
// lws_pkg: shared types and constants for the latency window statistics block
// no dependencies; imported by lws_ctrl, lws_datapath and latency_window_stats_core
package lws_pkg;

    localparam int TIME_W = 48;
    localparam int LAT_W  = 40;

    // sentinels that min and max start from: ten million ms and minus one ms
    localparam logic signed [LAT_W-1:0] LOW_START  = 40'sd10000000000;
    localparam logic signed [LAT_W-1:0] HIGH_START = -40'sd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } lws_state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_init;
        logic div_step;
        logic load_out;
    } lws_cmd_t;

endpackage

// ===== hdl/latency_window_stats_core.sv =====
// latency_window_stats_core: top level of the latency window statistics block
// depends on lws_pkg, lws_ctrl and lws_datapath
//
// usage
//   input channel s_*: one item carries an arrival time and a source stamp
//   time, both 48-bit microseconds. result channel m_*: one item per input,
//   giving the saturated latency, the truncated mean over the last WINDOW
//   latencies, the min and max since reset, and a window-full flag
//   sequence: an item is captured on acceptance, then goes through the window
//   update, the divider set-up and the serial restoring divider, one quotient
//   bit a cycle over SUM_W = 40 + clog2(WINDOW) bits, then the output load
//   throughput: one item at a time; s_ready returns the cycle after the
//   result is loaded into the output register
//   stall: the output register holds a finished result while the next item
//   is accepted and worked on; that item waits in the last step until the
//   receiver takes the earlier result
//   reset: synchronous active-low aresetn empties the window, zeroes the
//   running sum and restarts min/max from their sentinels; the ring memory
//   itself is not cleared, as only written entries are ever read
module latency_window_stats_core
    import lws_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [TIME_W-1:0]       s_arrival_time,
    input  logic [TIME_W-1:0]       s_stamp_time,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [LAT_W-1:0] m_latency,
    output logic signed [LAT_W-1:0] m_average_latency,
    output logic signed [LAT_W-1:0] m_min_latency,
    output logic signed [LAT_W-1:0] m_max_latency,
    output logic                    m_window_full
);

    // sum of WINDOW signed 40-bit latencies
    localparam int SUM_W = LAT_W + $clog2(WINDOW);

    lws_cmd_t cmd;

    lws_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lws_datapath #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_arrival_time    (s_arrival_time),
        .s_stamp_time      (s_stamp_time),
        .m_latency         (m_latency),
        .m_average_latency (m_average_latency),
        .m_min_latency     (m_min_latency),
        .m_max_latency     (m_max_latency),
        .m_window_full     (m_window_full)
    );

    // one item in flight: no new item the cycle after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after an accepted item");

    // min and max are taken over every latency, so they bound the current latency
    a_lat_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_latency <= m_latency) && (m_latency <= m_max_latency))
        else $error("latency outside min/max");

    // a truncated mean of window entries lies within the running min and max
    a_avg_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_latency <= m_average_latency)
                 && (m_average_latency <= m_max_latency))
        else $error("average outside min/max");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

// ===== hdl/lws_ctrl.sv =====
// lws_ctrl: sequencing state machine for the latency window statistics block
// depends on lws_pkg; drives the datapath through lws_cmd_t
module lws_ctrl
    import lws_pkg::*;
#(
    parameter int DIV_STEPS = 47
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output lws_cmd_t cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DIV_STEPS - 1);

    lws_state_t       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             m_valid_reg, m_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:    if (step_reg == '0) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        step_next    = step_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_PREP: begin
                cmd.div_init = 1'b1;
                step_next    = STEP_LAST;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
            end
            ST_OUT:  cmd.load_out = !m_valid_reg || m_ready;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/lws_datapath.sv =====
// lws_datapath: latency, ring store, running sum, min/max, serial divider, result regs
// depends on lws_pkg; sequenced by lws_ctrl through lws_cmd_t
module lws_datapath
    import lws_pkg::*;
#(
    parameter int WINDOW = 100,
    parameter int SUM_W  = 47
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lws_cmd_t                cmd,
    input  logic [TIME_W-1:0]       s_arrival_time,
    input  logic [TIME_W-1:0]       s_stamp_time,
    output logic signed [LAT_W-1:0] m_latency,
    output logic signed [LAT_W-1:0] m_average_latency,
    output logic signed [LAT_W-1:0] m_min_latency,
    output logic signed [LAT_W-1:0] m_max_latency,
    output logic                    m_window_full
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [AW-1:0] WLAST = AW'(WINDOW - 1);
    localparam logic [CW-1:0] WFULL = CW'(WINDOW);

    logic [LAT_W-1:0] ring_mem [WINDOW];
    logic [LAT_W-1:0] rd_reg;

    logic [AW-1:0]           wpos_reg, wpos_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [LAT_W-1:0] min_reg, min_next;
    logic signed [LAT_W-1:0] max_reg, max_next;

    logic signed [LAT_W-1:0] lat_reg;
    logic [SUM_W-1:0]        dvd_reg;
    logic [CW-1:0]           rem_reg;
    logic                    neg_reg;

    logic signed [TIME_W:0]  diff;
    logic signed [LAT_W-1:0] lat_sat;
    logic                    full;
    logic signed [SUM_W-1:0] old_ext;
    logic [CW:0]             trial;
    logic                    trial_ge;
    logic [SUM_W-1:0]        quo;

    // saturate arrival minus stamp to 40-bit two's complement
    always_comb begin
        diff = $signed({1'b0, s_arrival_time}) - $signed({1'b0, s_stamp_time});
        if (!diff[TIME_W] && (|diff[TIME_W-1:LAT_W-1])) begin
            lat_sat = {1'b0, {(LAT_W-1){1'b1}}};
        end else if (diff[TIME_W] && !(&diff[TIME_W-1:LAT_W-1])) begin
            lat_sat = {1'b1, {(LAT_W-1){1'b0}}};
        end else begin
            lat_sat = diff[LAT_W-1:0];
        end
    end

    // window bookkeeping
    always_comb begin
        full       = (count_reg == WFULL);
        old_ext    = full ? SUM_W'($signed(rd_reg)) : '0;
        sum_next   = sum_reg;
        count_next = count_reg;
        wpos_next  = wpos_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (cmd.update) begin
            sum_next   = sum_reg - old_ext + SUM_W'(lat_reg);
            count_next = full ? count_reg : count_reg + 1'b1;
            wpos_next  = (wpos_reg == WLAST) ? '0 : wpos_reg + 1'b1;
            if (lat_reg < min_reg) min_next = lat_reg;
            if (lat_reg > max_reg) max_next = lat_reg;
        end
    end

    // restoring division step on the magnitude
    always_comb begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, count_reg});
        quo      = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[wpos_reg] <= lat_reg;
        end
        rd_reg <= ring_mem[wpos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= LOW_START;
            max_reg   <= HIGH_START;
        end else begin
            wpos_reg  <= wpos_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lat_reg <= lat_sat;
        end
        if (cmd.div_init) begin
            neg_reg <= sum_reg[SUM_W-1];
            dvd_reg <= sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? CW'(trial - {1'b0, count_reg}) : trial[CW-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], trial_ge};
        end
        if (cmd.load_out) begin
            m_latency         <= lat_reg;
            m_average_latency <= quo[LAT_W-1:0];
            m_min_latency     <= min_reg;
            m_max_latency     <= max_reg;
            m_window_full     <= full;
        end
    end

endmodule

// ===== verif/latency_window_stats_core_test.sv =====
// latency_window_stats_core_test: self-checking bench for latency_window_stats_core
// depends on lws_pkg and the core; a directed table comes first, then random items;
// typed rows are checked against their written-out result, the rest against a predictor held in this file
`timescale 1ns / 1ps

module latency_window_stats_core_test
    import lws_pkg::*;
();

    localparam int WINDOW         = 100;
    localparam int N_RANDOM       = 750;
    localparam int N_TAIL         = 100;    // last random items run with no idling
    localparam int SETTLE_CYCLES  = 60;     // wait after draining, before the verdict
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int MAX_REPORTS    = 10;

    // saturation bounds of a 40-bit latency
    localparam logic signed [LAT_W-1:0] LAT_HI = 40'sh7F_FFFF_FFFF;
    localparam logic signed [LAT_W-1:0] LAT_LO = 40'sh80_0000_0000;
    localparam longint LAT_TOP    = 64'sd549755813887;
    localparam longint LAT_BOTTOM = -64'sd549755813888;
    localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [LAT_W-1:0] latency;
        logic signed [LAT_W-1:0] average;
        logic signed [LAT_W-1:0] lowest;
        logic signed [LAT_W-1:0] highest;
        logic                    full;
    } stats_t;

    // one row of the directed table; typed rows carry their result written out
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        stats_t            want;
    } stim_row_t;

    localparam int N_DIRECTED = 19;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // first latency far above ten million ms: min keeps its start value
        '{TIME_MAX, 48'd0, 1'b1, '{LAT_HI, LAT_HI, LOW_START, LAT_HI, 1'b0}},
        // most negative latency; the mean of the two extremes truncates to zero
        '{48'd0, TIME_MAX, 1'b1, '{LAT_LO, 40'sd0, LAT_LO, LAT_HI, 1'b0}},
        '{TIME_MAX, TIME_MAX, 1'b1, '{40'sd0, 40'sd0, LAT_LO, LAT_HI, 1'b0}},
        '{48'd0, 48'd0, 1'b1, '{40'sd0, 40'sd0, LAT_LO, LAT_HI, 1'b0}},
        // either side of both saturation bounds
        '{48'h7F_FFFF_FFFF, 48'd0, 1'b0, '0},
        '{48'h80_0000_0000, 48'd0, 1'b0, '0},
        '{48'd0, 48'h80_0000_0000, 1'b0, '0},
        '{48'd0, 48'h80_0000_0001, 1'b0, '0},
        // alternating bit patterns
        '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, '0},
        '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
        // values around the sentinels
        '{48'd1000, 48'd0, 1'b0, '0},
        '{48'd0, 48'd1000, 1'b0, '0},
        '{48'd1000001, 48'd1, 1'b0, '0},
        '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0, '0},
        '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 1'b0, '0},
        '{48'd10000000005, 48'd5, 1'b0, '0},
        '{48'd123456789, 48'd123456000, 1'b0, '0},
        '{48'd0, 48'd1, 1'b0, '0},
        '{48'd3, 48'd0, 1'b0, '0}
    };

    // ---------------------------------------------------------------- signals
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [TIME_W-1:0]       s_arrival_time = '0;
    logic [TIME_W-1:0]       s_stamp_time = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [LAT_W-1:0] m_latency;
    logic signed [LAT_W-1:0] m_average_latency;
    logic signed [LAT_W-1:0] m_min_latency;
    logic signed [LAT_W-1:0] m_max_latency;
    logic                    m_window_full;

    always #5 aclk = ~aclk;

    latency_window_stats_core #(
        .WINDOW (WINDOW)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_arrival_time    (s_arrival_time),
        .s_stamp_time      (s_stamp_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_latency         (m_latency),
        .m_average_latency (m_average_latency),
        .m_min_latency     (m_min_latency),
        .m_max_latency     (m_max_latency),
        .m_window_full     (m_window_full)
    );

    // ------------------------------------------------------ predictor state
    // the ring is only read once written, so its start value never matters
    longint ring_lat [WINDOW];
    int     wr_slot      = 0;
    int     held         = 0;
    longint window_total = 0;
    longint seen_low     = LOW_START;
    longint seen_high    = HIGH_START;

    stats_t expected_stats [$];
    int     fail_count   = 0;
    int     quiet_cycles = 0;
    int     hold_cnt     = 0;
    bit     gaps_on      = 1'b0;
    bit     stalls_on    = 1'b0;

    function automatic longint clamp_lat(input longint v);
        if (v > LAT_TOP) return LAT_TOP;
        if (v < LAT_BOTTOM) return LAT_BOTTOM;
        return v;
    endfunction

    // advance the window by one latency and work out the item that should come back
    function automatic stats_t predict_stats(input logic [TIME_W-1:0] arr,
                                             input logic [TIME_W-1:0] stm);
        longint lat;
        longint mean;
        stats_t r;
        lat = clamp_lat(longint'({16'd0, arr}) - longint'({16'd0, stm}));
        // once full, the oldest entry leaves the sum before the new one lands
        if (held == WINDOW) begin
            window_total -= ring_lat[wr_slot];
        end else begin
            held++;
        end
        ring_lat[wr_slot] = lat;
        window_total += lat;
        wr_slot = (wr_slot + 1) % WINDOW;
        // signed division truncates toward zero, as the block does
        mean = clamp_lat(window_total / held);
        if (lat < seen_low) seen_low = lat;
        if (lat > seen_high) seen_high = lat;
        r.latency = lat[LAT_W-1:0];
        r.average = mean[LAT_W-1:0];
        r.lowest  = seen_low[LAT_W-1:0];
        r.highest = seen_high[LAT_W-1:0];
        r.full    = (held == WINDOW);
        return r;
    endfunction

    // ---------------------------------------------------------- sender side
    // present one item, hold it until taken, then record what it should give
    task automatic send_item(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] stm,
                             input bit typed, input stats_t want);
        stats_t calc;
        s_valid        <= 1'b1;
        s_arrival_time <= arr;
        s_stamp_time   <= stm;
        do @(posedge aclk); while (!s_ready);
        // predictor always runs so its state follows the block
        calc = predict_stats(arr, stm);
        expected_stats.insert(expected_stats.size(), typed ? want : calc);
    endtask

    // random idle burst; half of them start once the block is ready again so
    // the gap lands in its idle phase rather than while it works
    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge aclk); while (!s_ready);
            end
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------- result side
    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_latency, m_average_latency, m_min_latency, m_max_latency,
                        m_window_full};
                if (expected_stats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%t: result item with nothing expected: lat %0d",
                                 $realtime, got.latency);
                end else begin
                    want = expected_stats.pop_front();
                    if (got.latency !== want.latency || got.average !== want.average ||
                        got.lowest !== want.lowest || got.highest !== want.highest ||
                        got.full !== want.full) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%t: mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                                     $realtime,
                                     want.latency, want.average, want.lowest,
                                     want.highest, want.full, got.latency, got.average,
                                     got.lowest, got.highest, got.full);
                    end
                end
            end
            // receiver stalls in bursts, only while enabled
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                if (hold_cnt == 1) m_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                m_ready  <= 1'b0;
                hold_cnt <= $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("** latency_window_stats_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------- stimulus
    initial begin
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] stm;
        logic [63:0]       r64;
        longint            lat;
        int                bias;
        int                pick;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: extremes, bounds and sentinels, with mild idling
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i != 0) maybe_pause();
            send_item(DIRECTED[i].arrival, DIRECTED[i].stamp, DIRECTED[i].typed,
                      DIRECTED[i].want);
        end
        // hold the sender back until the block has emptied
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            // every fifty items pick a new idling mix; quiet in the tail
            if (i % 50 == 0) begin
                gaps_on   = (i < N_RANDOM - N_TAIL) && ($urandom_range(0, 3) != 0);
                stalls_on = (i < N_RANDOM - N_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if (i % 150 == 149) wait_drained();
            // one block leans to saturated-high latencies, the next to saturated-low,
            // so the running sum gets near its limits with a full window
            bias = (i / 120 == 2) ? 1 : (i / 120 == 3) ? 2 : 0;
            pick = $urandom_range(0, 99);
            r64  = {$urandom, $urandom};
            stm  = r64[TIME_W-1:0];
            if (bias != 0 && pick < 80) begin
                r64 = {$urandom, $urandom};
                if (bias == 1) begin
                    arr = {4'hF, r64[43:0]};
                    stm = {16'd0, r64[63:32]};
                end else begin
                    arr = {16'd0, r64[63:32]};
                    stm = {4'hF, r64[43:0]};
                end
            end else if (pick < 60) begin
                // ordinary traffic: a few seconds of latency, sometimes negative
                lat = longint'($urandom_range(0, 4000000)) - 100000;
                arr = stm + 48'(lat);
            end else if (pick < 72) begin
                r64 = {$urandom, $urandom};
                arr = r64[TIME_W-1:0];
            end else if (pick < 84) begin
                // a few microseconds either side of a saturation bound
                lat = ($urandom_range(0, 1) == 1) ? longint'(LAT_TOP) + 1 : LAT_BOTTOM;
                lat = lat + longint'($urandom_range(0, 8)) - 4;
                stm = 48'h100_0000_0000 + {16'd0, $urandom};
                arr = stm + 48'(lat);
            end else if (pick < 92) begin
                arr = ($urandom_range(0, 1) == 1) ? TIME_MAX : '0;
                stm = ($urandom_range(0, 1) == 1) ? TIME_MAX : '0;
            end else begin
                arr = stm + 48'(longint'($urandom_range(0, 6)) - 3);
            end
            maybe_pause();
            send_item(arr, stm, 1'b0, '0);
        end

        wait_drained();
        // room for any stray item the block might still put out
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** latency_window_stats_core: PASSED **");
        end else begin
            $display("** latency_window_stats_core: FAILED **");
        end
        $finish;
    end

endmodule
